FILE: hdl/efcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcs_pkg
// Shared constants, widths and helpers of the earliest-free-core scheduler.
// ----------------------------------------------------------------------------
package efcs_pkg;

  localparam int MAX_CORES  = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int IDX_W      = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int N_W        = $clog2(MAX_CORES + 1);
  localparam int CH_W       = IDX_W + 2;
  localparam int BANK_DEPTH = (MAX_CORES + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int RESET_CORES = 4;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [N_W-1:0]    count_t;

  // Map a written core count onto 1..MAX_CORES.
  function automatic count_t clamp_cores(input logic [CFG_W-1:0] v);
    int unsigned vi;
    vi = int'(v);
    if (vi == 0) begin
      return count_t'(1);
    end else if (vi > MAX_CORES) begin
      return count_t'(MAX_CORES);
    end
    return count_t'(vi);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/efcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcs_task_if / efcs_result_if
// Valid/ready channels for incoming tasks and outgoing dispatch results.
// ----------------------------------------------------------------------------
interface efcs_task_if;
  logic                     valid;
  logic                     ready;
  logic [efcs_pkg::DATA_W-1:0] arrival_time;
  logic [efcs_pkg::DATA_W-1:0] duration;

  modport source (output valid, output arrival_time, output duration, input ready);
  modport sink   (input valid, input arrival_time, input duration, output ready);
endinterface

interface efcs_result_if;
  logic                     valid;
  logic                     ready;
  logic [efcs_pkg::DATA_W-1:0] start_time;
  logic [efcs_pkg::DATA_W-1:0] finish_time;
  logic [efcs_pkg::DATA_W-1:0] makespan;
  logic                     saturated;

  modport source (output valid, output start_time, output finish_time, output makespan,
                  output saturated, input ready);
  modport sink   (input valid, input start_time, input finish_time, input makespan,
                  input saturated, output ready);
endinterface
`default_nettype wire

FILE: hdl/efcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module efcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/earliest_free_core_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_free_core_scheduler_core
// Dispatches tasks to the core that frees up first, using a min-heap of
// core finish times held in two banked RAMs.
// ----------------------------------------------------------------------------
// One task at a time: after a task is accepted the block first does the
// start/finish arithmetic in state ST_CALC, then sifts the new finish time
// down the heap at one level per cycle in ST_SIFT, then places it in ST_PUT,
// and only after that accepts the next task. The sift-down keeps that pace
// because the two children of a heap node sit in separate RAM banks and are
// read together, and the root is kept in a register. A
// finished result waits in the output register; the next task is accepted and
// sifted meanwhile, but it is not placed, and no further task is accepted,
// until that register empties. Writing cfg_data under cfg_we sets the core
// count (0 means one core, values above MAX_CORES clamp) and clears every
// finish time and the makespan; write it only while no task is in flight.
// ----------------------------------------------------------------------------
module earliest_free_core_scheduler_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  efcs_task_if.sink                       in_task,
  efcs_result_if.source                   out_res,
  input  wire logic                       cfg_we,
  input  wire logic [efcs_pkg::CFG_W-1:0] cfg_data
);
  import efcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_SIFT = 4'b0100,
    ST_PUT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  count_t              cores_r;
  data_t               root_r;
  data_t               makespan_r;
  data_t               start_r;
  data_t               dur_r;
  data_t               val_r;
  logic                sat_r;
  logic [IDX_W-1:0]    hole_r;
  logic [BANK_DEPTH-1:0] vld_l_r, vld_r_r;
  logic                rvld_l_r, rvld_r_r;

  data_t               out_start_r, out_finish_r, out_mk_r;
  logic                out_sat_r, out_valid_r;

  // arithmetic
  logic [DATA_W:0]     sum;
  data_t               finish;
  data_t               start_in;

  // sift-down
  logic [CH_W-1:0]     child_l, child_r;
  logic                l_ok, r_ok, take_l, take_r, moved;
  data_t               rd_l, rd_r, lv, rv, cur_v, child_v;
  logic [IDX_W-1:0]    best;

  // RAM ports
  logic                rd_en;
  logic [IDX_W-1:0]    rd_node;
  logic [BANK_AW-1:0]  rd_addr;
  logic                wr_en;
  data_t               wr_val;
  logic [IDX_W-1:0]    wr_half;
  logic [BANK_AW-1:0]  wr_addr;
  logic                we_l, we_r, wr_root;
  logic                out_load;

  assign in_task.ready = (state_r == ST_IDLE);
  assign start_in = (in_task.arrival_time > root_r) ? in_task.arrival_time : root_r;

  assign sum    = {1'b0, start_r} + {1'b0, dur_r};
  assign finish = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];

  // Children of the hole node: left in bank L, right in bank R, same address.
  assign child_l = {1'b0, hole_r, 1'b1};
  assign child_r = child_l + CH_W'(1);
  assign l_ok    = child_l < CH_W'(cores_r);
  assign r_ok    = child_r < CH_W'(cores_r);
  assign lv      = rvld_l_r ? rd_l : '0;
  assign rv      = rvld_r_r ? rd_r : '0;
  assign take_l  = l_ok && (lv < val_r);
  assign cur_v   = take_l ? lv : val_r;
  assign take_r  = r_ok && (rv < cur_v);
  assign moved   = take_l || take_r;
  assign child_v = take_r ? rv : lv;
  assign best    = take_r ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_node = '0;
    case (state_r)
      ST_CALC: begin
        rd_en   = 1'b1;
        rd_node = '0;
      end
      ST_SIFT: begin
        rd_en   = moved;
        rd_node = best;
      end
      default: begin
        rd_en   = 1'b0;
        rd_node = '0;
      end
    endcase
  end
  assign rd_addr = rd_node[BANK_AW-1:0];

  // Fill the hole with the smaller child while sifting, with the task's
  // finish time once it has settled.
  assign wr_en   = ((state_r == ST_SIFT) && moved) || (state_r == ST_PUT);
  assign wr_val  = (state_r == ST_SIFT) ? child_v : val_r;
  assign wr_root = wr_en && (hole_r == '0);
  assign we_l    = wr_en && hole_r[0];
  assign we_r    = wr_en && !hole_r[0] && (hole_r != '0);
  assign wr_half = hole_r[0] ? (hole_r >> 1) : ((hole_r >> 1) - IDX_W'(1));
  assign wr_addr = wr_half[BANK_AW-1:0];

  assign out_load = (state_r == ST_PUT) && (!out_valid_r || out_res.ready);

  efcs_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_bank_l (
    .clk   (clk),
    .we    (we_l),
    .waddr (wr_addr),
    .wdata (wr_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_l)
  );

  efcs_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_bank_r (
    .clk   (clk),
    .we    (we_r),
    .waddr (wr_addr),
    .wdata (wr_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_r)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_task.valid) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_SIFT;
      ST_SIFT: if (!moved) state_nxt = ST_PUT;
      ST_PUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cores_r     <= count_t'(RESET_CORES);
      root_r      <= '0;
      makespan_r  <= '0;
      vld_l_r     <= '0;
      vld_r_r     <= '0;
      rvld_l_r    <= 1'b0;
      rvld_r_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        cores_r    <= clamp_cores(cfg_data);
        root_r     <= '0;
        makespan_r <= '0;
        vld_l_r    <= '0;
        vld_r_r    <= '0;
      end else begin
        if (wr_root) root_r <= wr_val;
        if (we_l) vld_l_r[wr_addr] <= 1'b1;
        if (we_r) vld_r_r[wr_addr] <= 1'b1;
        if ((state_r == ST_CALC) && (finish > makespan_r)) makespan_r <= finish;
      end

      if (rd_en) begin
        rvld_l_r <= vld_l_r[rd_addr];
        rvld_r_r <= vld_r_r[rd_addr];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_task.valid && in_task.ready) begin
      start_r <= start_in;
      dur_r   <= in_task.duration;
    end
    if (state_r == ST_CALC) begin
      val_r  <= finish;
      sat_r  <= sum[DATA_W];
      hole_r <= '0;
    end else if ((state_r == ST_SIFT) && moved) begin
      hole_r <= best;
    end
    if (out_load) begin
      out_start_r  <= start_r;
      out_finish_r <= val_r;
      out_mk_r     <= makespan_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.start_time  = out_start_r;
  assign out_res.finish_time = out_finish_r;
  assign out_res.makespan    = out_mk_r;
  assign out_res.saturated   = out_sat_r;

endmodule
`default_nettype wire

FILE: hdl/efcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcs_checker
// Port-level checks on the scheduler's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module efcs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [efcs_pkg::DATA_W-1:0] start_time,
  input wire logic [efcs_pkg::DATA_W-1:0] finish_time,
  input wire logic [efcs_pkg::DATA_W-1:0] makespan,
  input wire logic                        saturated
);

  // Hold a result until the sink takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction completed");

  a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> finish_time >= start_time)
    else $error("finish time earlier than start time");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> finish_time == {efcs_pkg::DATA_W{1'b1}})
    else $error("saturated result not clamped to the maximum");

  a_makespan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> makespan >= finish_time)
    else $error("makespan below the reported finish time");

endmodule

bind earliest_free_core_scheduler_core efcs_checker u_efcs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .start_time  (out_res.start_time),
  .finish_time (out_res.finish_time),
  .makespan    (out_res.makespan),
  .saturated   (out_res.saturated)
);
`default_nettype wire

FILE: tb/sv/tb_earliest_free_core_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_earliest_free_core_scheduler_core
// Self-checking bench for the earliest-free-core scheduler. A local min-heap
// of core finish times predicts start, finish, makespan and saturation for
// each accepted task. Each dispatch result is checked against the oldest
// prediction. Directed tests cover the field extremes, saturation and
// core-count clamping. Random traffic runs under several idle and stall
// mixes, and a long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_earliest_free_core_scheduler_core;
  import efcs_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    data_t start_time;
    data_t finish_time;
    data_t makespan;
    logic  saturated;
  } dispatch_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  efcs_task_if   task_ch ();
  efcs_result_if res_ch ();

  earliest_free_core_scheduler_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_task  (task_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: min-heap of core finish times.
  data_t       core_free_at [MAX_CORES];
  int unsigned pool_size;
  data_t       span_so_far;
  dispatch_t   pending_dispatch [$];

  int   error_count;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  bit   hold_request;
  int   hold_left;
  data_t workload_now;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_pool();
    for (int i = 0; i < MAX_CORES; i++) core_free_at[i] = '0;
    span_so_far = '0;
  endfunction

  function automatic dispatch_t predict_dispatch(input data_t arr, input data_t dur);
    dispatch_t       r;
    logic [DATA_W:0] sum;
    int unsigned     pos;
    int unsigned     lc;
    int unsigned     best;
    data_t           tmp;
    r.start_time = (arr > core_free_at[0]) ? arr : core_free_at[0];
    sum = {1'b0, r.start_time} + {1'b0, dur};
    r.saturated = sum[DATA_W];
    r.finish_time = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    // Replace the root and sift it down.
    core_free_at[0] = r.finish_time;
    pos = 0;
    forever begin
      lc = 2 * pos + 1;
      best = pos;
      if (lc < pool_size && core_free_at[lc] < core_free_at[best]) best = lc;
      if (lc + 1 < pool_size && core_free_at[lc + 1] < core_free_at[best]) best = lc + 1;
      if (best == pos) break;
      tmp = core_free_at[pos];
      core_free_at[pos] = core_free_at[best];
      core_free_at[best] = tmp;
      pos = best;
    end
    if (r.finish_time > span_so_far) span_so_far = r.finish_time;
    r.makespan = span_so_far;
    return r;
  endfunction

  // Output ready: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    dispatch_t exp_d;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_dispatch.size() == 0) begin
        $error("unexpected result: start_time %0h finish_time %0h", res_ch.start_time,
               res_ch.finish_time);
        error_count++;
      end else begin
        exp_d = pending_dispatch.pop_front();
        if (res_ch.start_time !== exp_d.start_time) begin
          $error("start_time: expected %0h, actual %0h", exp_d.start_time, res_ch.start_time);
          error_count++;
        end
        if (res_ch.finish_time !== exp_d.finish_time) begin
          $error("finish_time: expected %0h, actual %0h", exp_d.finish_time,
                 res_ch.finish_time);
          error_count++;
        end
        if (res_ch.makespan !== exp_d.makespan) begin
          $error("makespan: expected %0h, actual %0h", exp_d.makespan, res_ch.makespan);
          error_count++;
        end
        if (res_ch.saturated !== exp_d.saturated) begin
          $error("saturated: expected %0b, actual %0b", exp_d.saturated, res_ch.saturated);
          error_count++;
        end
      end
    end
  end

  task automatic send_task(input data_t arr, input data_t dur);
    if ($urandom_range(99) < sender_idle_pct) begin
      task_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    task_ch.valid        <= 1'b1;
    task_ch.arrival_time <= arr;
    task_ch.duration     <= dur;
    do @(posedge clk); while (!task_ch.ready);
    pending_dispatch.push_back(predict_dispatch(arr, dur));
  endtask

  task automatic wait_all_dispatched();
    task_ch.valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_core_count(input logic [CFG_W-1:0] value);
    wait_all_dispatched();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value == 0) pool_size = 1;
    else if (value > MAX_CORES) pool_size = MAX_CORES;
    else pool_size = int'(value);
    clear_pool();
  endtask

  // Mostly a steady workload on a running clock; now and then raw 32-bit
  // values or arrivals close to the top of the range.
  task automatic send_random_task();
    data_t arr;
    data_t dur;
    case ($urandom_range(19))
      0, 1: begin
        arr = $urandom;
        dur = $urandom;
      end
      2: begin
        arr = {DATA_W{1'b1}} - $urandom_range(2000);
        dur = $urandom_range(3000);
      end
      3: begin
        arr = workload_now;
        dur = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(5000);
      end
      default: begin
        workload_now = workload_now + $urandom_range(30);
        arr = workload_now - $urandom_range(20);
        dur = $urandom_range(1, 300);
      end
    endcase
    send_task(arr, dur);
  endtask

  task automatic test_reset_defaults();
    // Four cores after reset: the fifth task waits for the shortest one.
    send_task(32'd0, 32'd10);
    send_task(32'd0, 32'd20);
    send_task(32'd0, 32'd30);
    send_task(32'd0, 32'd40);
    send_task(32'd0, 32'd5);
  endtask

  task automatic test_field_extremes();
    write_core_count(7'd1);
    send_task(32'hFFFF_FFFF, 32'd0);
    send_task(32'd0, 32'hFFFF_FFFF);
    write_core_count(7'd2);
    send_task(32'hFFFF_FFFE, 32'd1);
    send_task(32'hFFFF_FFFF, 32'd1);
    send_task(32'd0, 32'hFFFF_FFFF);
    send_task(32'hAAAA_AAAA, 32'h5555_5555);
    send_task(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_core_count_clamp();
    // Zero means one core: tasks run back to back.
    write_core_count(7'd0);
    send_task(32'd0, 32'd5);
    send_task(32'd0, 32'd5);
    send_task(32'd0, 32'd5);
    // Above the maximum clamps to the full pool.
    write_core_count(7'd127);
    send_task(32'd3, 32'd7);
    send_task(32'd1, 32'd7);
    write_core_count(7'd65);
    send_task(32'd0, 32'd9);
    send_task(32'd2, 32'd1);
    write_core_count(7'd64);
    send_task(32'd100, 32'd0);
  endtask

  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 86, 0, 21};
    int stall_mix [4] = '{0, 0, 86, 21};
    logic [CFG_W-1:0] counts [4];
    counts[0] = 7'd1;
    counts[1] = 7'd64;
    counts[2] = CFG_W'($urandom_range(2, 16));
    counts[3] = CFG_W'($urandom_range(0, 127));
    for (int ph = 0; ph < 4; ph++) begin
      write_core_count(counts[ph]);
      workload_now = '0;
      sender_idle_pct    = idle_mix[ph];
      receiver_stall_pct = stall_mix[ph];
      repeat (90) send_random_task();
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    write_core_count(CFG_W'($urandom_range(3, 12)));
    workload_now = '0;
    hold_request = 1'b1;
    repeat (40) send_random_task();
    wait_all_dispatched();
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    task_ch.valid        = 1'b0;
    task_ch.arrival_time = '0;
    task_ch.duration     = '0;
    res_ch.ready         = 1'b0;
    error_count          = 0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    hold_request         = 1'b0;
    hold_left            = 0;
    workload_now         = '0;
    pool_size            = RESET_CORES;
    clear_pool();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_core_count_clamp();
    test_random_traffic();
    test_output_backpressure();

    wait_all_dispatched();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_dispatch.size() != 0) begin
      $error("results missing: %0d", pending_dispatch.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
